@@ design/life_grid_generation_step_macros.svh @@
// Assertion helpers used by life_grid_generation_step.
`ifndef LIFE_GRID_GENERATION_STEP_MACROS_SVH
`define LIFE_GRID_GENERATION_STEP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LGS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lgs assertion failed");

// Next-cycle implication, checked out of reset.
`define LGS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lgs assertion failed");

`endif

@@ design/lgs_pkg.sv @@
`timescale 1ns / 1ps
package lgs_pkg;

    localparam int OP_W     = 2;
    localparam int COORD_W  = 6;
    localparam int CFG_W    = 7;
    localparam int APB_W    = 32;
    localparam int PADDR_W  = 3;
    localparam int COUNT_W  = 4;

    typedef enum logic [OP_W-1:0] {
        OP_TOGGLE = 2'd0,
        OP_SET    = 2'd1,
        OP_READ   = 2'd2,
        OP_STEP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EDIT,
        ST_SWEEP,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic [CFG_W-1:0] COLUMNS_RESET = 7'd50;
    localparam logic [CFG_W-1:0] ROWS_RESET    = 7'd50;

    localparam logic [COUNT_W-1:0] BIRTH_COUNT  = 4'd3;
    localparam logic [COUNT_W-1:0] SURVIVE_LOW  = 4'd2;
    localparam logic [COUNT_W-1:0] SURVIVE_HIGH = 4'd3;

endpackage

@@ design/lgs_ifs.sv @@
`timescale 1ns / 1ps
interface lgs_req_if
    import lgs_pkg::*;
;
    logic                valid;
    logic                ready;
    op_t                 op;
    logic [COORD_W-1:0]  cell_column;
    logic [COORD_W-1:0]  cell_row;
    logic                new_alive;

    modport source (output valid, op, cell_column, cell_row, new_alive, input ready);
    modport sink   (input valid, op, cell_column, cell_row, new_alive, output ready);
endinterface

interface lgs_rsp_if;
    logic valid;
    logic ready;
    logic cell_alive;
    logic step_finished;

    modport source (output valid, cell_alive, step_finished, input ready);
    modport sink   (input valid, cell_alive, step_finished, output ready);
endinterface

@@ design/life_grid_generation_step.sv @@
`timescale 1ns / 1ps
// Game of Life (B3/S23) grid engine.
// req: one transfer per command (toggle, set, read one cell, or step one
//   generation). rsp: exactly one transfer per command, in order.
// Config: APB registers columns_in_use at 0x0 and rows_in_use at 0x4;
//   values above the grid size saturate. Cells outside the active area
//   count as dead and are left unchanged by a step.
// Sequence: an edit or read passes through ST_EDIT (row write) and
//   ST_REPLY (output load); the idle state then takes the next req. A step
//   sweeps the active rows (rows_in_use saturated at GRID_ROWS): a row of
//   column cells sweeps the grid one row per cycle, paced by the single
//   read port of the row memory. One command is in flight at a time;
//   req.ready is high only while the engine is idle.
// Reset: every row is marked empty (reads as dead) through per-row valid
//   bits, so no clearing pass is needed; registers return to 50 x 50.
// Stall: a result waits in the output register while rsp.ready is low;
//   the next command may be taken meanwhile, and its result is held back
//   until the output register frees up.
module life_grid_generation_step
    import lgs_pkg::*;
#(
    parameter int GRID_COLUMNS = 64,
    parameter int GRID_ROWS    = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    lgs_req_if.sink            req,
    lgs_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);

`include "life_grid_generation_step_macros.svh"

    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam int NR_W  = $clog2(GRID_ROWS + 1);
    localparam int NC_W  = $clog2(GRID_COLUMNS + 1);

    // configuration
    logic [CFG_W-1:0] columns_reg;
    logic [CFG_W-1:0] columns_next;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] rows_next;
    logic             cfg_write;
    logic [NC_W-1:0]  nc;
    logic [NR_W-1:0]  nr;

    // control
    state_t             state_reg;
    state_t             state_next;
    op_t                op_reg;
    op_t                op_next;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] col_next;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] row_next;
    logic               val_reg;
    logic               val_next;
    logic [NR_W-1:0]    sweep_reg;
    logic [NR_W-1:0]    sweep_next;
    logic               res_alive_reg;
    logic               res_alive_next;
    logic               res_step_reg;
    logic               res_step_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_alive_reg;
    logic               out_alive_next;
    logic               out_step_reg;
    logic               out_step_next;
    logic [GRID_ROWS-1:0] row_valid_reg;
    logic [GRID_ROWS-1:0] row_valid_next;

    // datapath
    logic [ROW_W-1:0]        rd_addr;
    logic [GRID_COLUMNS-1:0] rd_data;
    logic                    wr_en;
    logic [ROW_W-1:0]        wr_addr;
    logic [GRID_COLUMNS-1:0] wr_data;
    logic [GRID_COLUMNS-1:0] active_cols;
    logic [GRID_COLUMNS-1:0] col_mask;
    logic [GRID_COLUMNS-1:0] old_row;
    logic [GRID_COLUMNS-1:0] edit_row;
    logic [GRID_COLUMNS-1:0] below_row;
    logic [GRID_COLUMNS-1:0] next_row;
    logic [ROW_W-1:0]        edit_idx;
    logic [ROW_W-1:0]        sweep_idx;
    logic                    in_area;
    logic                    load_out;
    cell_ctrl_t              ctrl;

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ROWS) ? APB_W'(rows_reg) : APB_W'(columns_reg);

    always_comb
    begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        if (cfg_write)
        begin
            if (paddr[2] == REG_ROWS)
                rows_next = pwdata[CFG_W-1:0];
            else
                columns_next = pwdata[CFG_W-1:0];
        end
    end

    assign nc = (int'(columns_reg) > GRID_COLUMNS) ? NC_W'(GRID_COLUMNS) : NC_W'(columns_reg);
    assign nr = (int'(rows_reg) > GRID_ROWS) ? NR_W'(GRID_ROWS) : NR_W'(rows_reg);

    always_comb
    begin
        for (int c = 0; c < GRID_COLUMNS; c++)
        begin
            active_cols[c] = (c < int'(nc));
            col_mask[c]    = (int'(col_reg) == c);
        end
    end

    // ---------------- row storage ----------------
    lgs_row_mem #(
        .ROWS  (GRID_ROWS),
        .WIDTH (GRID_COLUMNS)
    ) u_row_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lgs_cell_row #(
        .COLUMNS (GRID_COLUMNS)
    ) u_cell_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .active    (active_cols),
        .below_row (below_row),
        .next_row  (next_row)
    );

    assign edit_idx  = ROW_W'(row_reg);
    assign sweep_idx = sweep_reg[ROW_W-1:0];
    assign in_area   = (int'(col_reg) < int'(nc)) && (int'(row_reg) < int'(nr));
    assign old_row   = row_valid_reg[edit_idx] ? rd_data : '0;
    assign below_row = ((sweep_reg < nr) && row_valid_reg[sweep_idx]) ? rd_data : '0;

    always_comb
    begin
        case (op_reg)
            OP_TOGGLE: edit_row = old_row ^ col_mask;
            OP_SET:    edit_row = val_reg ? (old_row | col_mask) : (old_row & ~col_mask);
            default:   edit_row = old_row;
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg   <= COLUMNS_RESET;
            rows_reg      <= ROWS_RESET;
            state_reg     <= ST_IDLE;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            columns_reg   <= columns_next;
            rows_reg      <= rows_next;
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
            row_valid_reg <= row_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        val_reg       <= val_next;
        res_alive_reg <= res_alive_next;
        res_step_reg  <= res_step_next;
        out_alive_reg <= out_alive_next;
        out_step_reg  <= out_step_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        val_next       = val_reg;
        sweep_next     = sweep_reg;
        res_alive_next = res_alive_reg;
        res_step_next  = res_step_reg;
        row_valid_next = row_valid_reg;
        ctrl           = '0;
        rd_addr        = ROW_W'(req.cell_row);
        wr_en          = 1'b0;
        wr_addr        = edit_idx;
        wr_data        = edit_row;
        req.ready      = 1'b0;
        load_out       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.op == OP_STEP)
                    rd_addr = '0;
                if (req.valid)
                begin
                    op_next  = req.op;
                    col_next = req.cell_column;
                    row_next = req.cell_row;
                    val_next = req.new_alive;
                    if (req.op == OP_STEP)
                    begin
                        ctrl.clear = 1'b1;
                        sweep_next = '0;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_EDIT;
                    end
                end
            end

            ST_EDIT:
            begin
                wr_en          = in_area && (op_reg != OP_READ);
                res_alive_next = in_area && ((edit_row & col_mask) != '0);
                res_step_next  = 1'b0;
                if (wr_en)
                    row_valid_next[edit_idx] = 1'b1;
                state_next = ST_REPLY;
            end

            ST_SWEEP:
            begin
                // rd_data holds old row sweep_reg; cells produce row sweep_reg - 1
                ctrl.shift = 1'b1;
                rd_addr    = ROW_W'(sweep_reg + 1'b1);
                wr_addr    = ROW_W'(sweep_reg - 1'b1);
                wr_data    = next_row;
                if (sweep_reg != '0)
                begin
                    wr_en = 1'b1;
                    row_valid_next[wr_addr] = 1'b1;
                end
                if (sweep_reg == nr)
                begin
                    res_alive_next = 1'b0;
                    res_step_next  = 1'b1;
                    state_next     = ST_REPLY;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            ST_REPLY:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_alive_next = out_alive_reg;
        out_step_next  = out_step_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_alive_next = res_alive_reg;
            out_step_next  = res_step_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.cell_alive    = out_alive_reg;
    assign rsp.step_finished = out_step_reg;

    `LGS_ASSERT_NOW(a_write_when_busy, wr_en, (state_reg == ST_EDIT) || (state_reg == ST_SWEEP))
    `LGS_ASSERT_NOW(a_sweep_bounded, state_reg == ST_SWEEP, sweep_reg <= nr)
    `LGS_ASSERT_NEXT(a_reply_loads, load_out, out_valid_reg && (state_reg == ST_IDLE))
    `LGS_ASSERT_NOW(a_step_reads_dead, out_valid_reg && out_step_reg, !out_alive_reg)

endmodule

@@ design/lgs_cell.sv @@
`timescale 1ns / 1ps
module lgs_cell
    import lgs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       active,
    input  logic       below,
    input  logic [1:0] left_sum,
    input  logic [1:0] right_sum,
    output logic [1:0] col_sum,
    output logic       next_bit
);

    logic               above_reg;
    logic               above_next;
    logic               cur_reg;
    logic               cur_next;
    logic               self_bit;
    logic [COUNT_W-1:0] neighbors;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg <= 1'b0;
            cur_reg   <= 1'b0;
        end
        else
        begin
            above_reg <= above_next;
            cur_reg   <= cur_next;
        end
    end

    always_comb
    begin
        above_next = above_reg;
        cur_next   = cur_reg;
        if (ctrl.clear)
        begin
            above_next = 1'b0;
            cur_next   = 1'b0;
        end
        else if (ctrl.shift)
        begin
            above_next = cur_reg;
            cur_next   = below;
        end
    end

    // dead outside the active columns
    assign self_bit = cur_reg & active;
    assign col_sum  = active ? (2'(above_reg) + 2'(cur_reg) + 2'(below)) : 2'd0;
    assign neighbors = COUNT_W'(left_sum) + COUNT_W'(right_sum) + COUNT_W'(col_sum)
                     - COUNT_W'(self_bit);

    always_comb
    begin
        if (!active)
            next_bit = cur_reg;
        else if (self_bit)
            next_bit = (neighbors == SURVIVE_LOW) || (neighbors == SURVIVE_HIGH);
        else
            next_bit = (neighbors == BIRTH_COUNT);
    end

endmodule

@@ design/lgs_cell_row.sv @@
`timescale 1ns / 1ps
module lgs_cell_row
    import lgs_pkg::*;
#(
    parameter int COLUMNS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [COLUMNS-1:0] active,
    input  logic [COLUMNS-1:0] below_row,
    output logic [COLUMNS-1:0] next_row
);

    logic [1:0] sums [COLUMNS];

    for (genvar c = 0; c < COLUMNS; c++)
    begin : g_cell
        logic [1:0] left_sum;
        logic [1:0] right_sum;

        if (c == 0)
        begin : g_left_edge
            assign left_sum = 2'd0;
        end
        else
        begin : g_left
            assign left_sum = sums[c-1];
        end

        if (c == COLUMNS - 1)
        begin : g_right_edge
            assign right_sum = 2'd0;
        end
        else
        begin : g_right
            assign right_sum = sums[c+1];
        end

        lgs_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .active    (active[c]),
            .below     (below_row[c]),
            .left_sum  (left_sum),
            .right_sum (right_sum),
            .col_sum   (sums[c]),
            .next_bit  (next_row[c])
        );
    end

endmodule

@@ design/lgs_row_mem.sv @@
`timescale 1ns / 1ps
module lgs_row_mem #(
    parameter int ROWS  = 64,
    parameter int WIDTH = 64,
    localparam int AW   = $clog2(ROWS)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [ROWS];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
